// ===== rtl/square_matrix_rotate_cw_assert.svh =====
// ----------------------------------------------------------------------------
// square_matrix_rotate_cw assertion macros
// Concurrent assertion wrappers, same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_ROTATE_CW_ASSERT_SVH
`define SQUARE_MATRIX_ROTATE_CW_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SMRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SMRC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/smrc_pkg.sv =====
// ----------------------------------------------------------------------------
// smrc_pkg
// Shared constants and types of the square matrix rotator.
// ----------------------------------------------------------------------------
package smrc_pkg;

   localparam int MAX_SIZE_DEF = 8;
   localparam int VALUE_W      = 32;
   localparam int SIZE_W       = 4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } beat_type;

   typedef struct packed {
      logic head_vld;
      logic skid_vld;
   } buf_stat_type;

endpackage

// ===== rtl/square_matrix_rotate_cw.sv =====
// ----------------------------------------------------------------------------
// square_matrix_rotate_cw
// Loads a square matrix row-major into a store, then streams it out rotated
// 90 degrees clockwise, row-major, with the final beat flagged last.
//
//   channel  dir  handshake        payload
//   req      in   valid / stall    req_element_value
//   rsp      out  valid / stall    rsp_rotated_value, rsp_last_element
//   csr      in   valid / ready    csr_matrix_size
//
// Load: one element per cycle, written straight into the store.
// Emit: n*n reads through the single store read port, one per cycle while
//   the buffer has room; beats pass the read and buffer head registers.
// req is stalled while reads are issued; loading resumes once the last read
//   is issued. rsp stalls back-pressure reads through a two-entry buffer.
// Reset clears control only; the store has no clearing pass.
// ----------------------------------------------------------------------------
`include "square_matrix_rotate_cw_assert.svh"

module square_matrix_rotate_cw #(
   parameter int MAX_SIZE = smrc_pkg::MAX_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [smrc_pkg::VALUE_W-1:0] req_element_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [smrc_pkg::VALUE_W-1:0] rsp_rotated_value,
   output logic                                rsp_last_element,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [smrc_pkg::SIZE_W-1:0]  csr_matrix_size
);

   localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int SIDE_W = $clog2(MAX_SIZE + 1);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic [smrc_pkg::SIZE_W-1:0] size_ff;
   logic [0:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            load_cnt_ff, load_cnt_in;
   logic [SIDE_W-1:0]           side_ff, side_in;
   logic [SIDE_W-1:0]           r_ff, r_in;
   logic [SIDE_W-1:0]           c_ff, c_in;
   logic [ADDR_W-1:0]           base_ff, base_in;
   logic [ADDR_W-1:0]           src_ff, src_in;
   logic                        rd_pend_ff;
   logic                        rd_last_ff;
   logic [smrc_pkg::VALUE_W-1:0] rd_data_ff;

   logic [smrc_pkg::VALUE_W-1:0] store_mem [DEPTH];

   logic [SIDE_W-1:0] side_live;
   logic [CNT_W-1:0]  side_wide;
   logic [CNT_W-1:0]  total;
   logic [CNT_W-1:0]  cnt_next;
   logic              req_acc;
   logic              complete;
   logic              pop;
   logic              issue;
   logic              last_c;
   logic              last_r;
   logic [1:0]        occ;

   smrc_pkg::beat_type     push_beat;
   smrc_pkg::beat_type     head_beat;
   smrc_pkg::buf_stat_type buf_stat;

   // side length clamp
   always_comb begin
      if (size_ff == '0) begin
         side_live = SIDE_W'(1);
      end else if (size_ff > smrc_pkg::SIZE_W'(MAX_SIZE)) begin
         side_live = SIDE_W'(MAX_SIZE);
      end else begin
         side_live = size_ff[SIDE_W-1:0];
      end
   end

   assign side_wide = CNT_W'(side_live);
   assign total     = side_wide * side_wide;
   assign cnt_next  = load_cnt_ff + CNT_W'(1);
   assign req_stall = (state_ff == ST_EMIT);
   assign req_acc   = req_valid && !req_stall;
   assign complete  = req_acc && (cnt_next >= total);

   assign pop   = buf_stat.head_vld && !rsp_stall;
   assign occ   = 2'(buf_stat.head_vld) + 2'(buf_stat.skid_vld) + 2'(rd_pend_ff);
   assign issue = (state_ff == ST_EMIT) && ((occ < 2'd2) || ((occ == 2'd2) && pop));

   assign last_c = (c_ff == side_ff - SIDE_W'(1));
   assign last_r = (r_ff == side_ff - SIDE_W'(1));

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      side_in     = side_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      base_in     = base_ff;
      src_in      = src_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (complete) begin
               state_in    = ST_EMIT;
               load_cnt_in = '0;
               side_in     = side_live;
               r_in        = '0;
               c_in        = '0;
               base_in     = ADDR_W'(total - side_wide);
               src_in      = ADDR_W'(total - side_wide);
            end else if (req_acc) begin
               load_cnt_in = cnt_next;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               if (last_c) begin
                  c_in   = '0;
                  r_in   = r_ff + SIDE_W'(1);
                  src_in = base_ff + ADDR_W'(r_ff) + ADDR_W'(1);
                  if (last_r) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  c_in   = c_ff + SIDE_W'(1);
                  src_in = src_ff - ADDR_W'(side_ff);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= smrc_pkg::SIZE_RESET;
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            size_ff <= csr_matrix_size;
         end
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         rd_pend_ff  <= issue;
      end
      side_ff    <= side_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      base_ff    <= base_in;
      src_ff     <= src_in;
      rd_last_ff <= last_c && last_r;
   end

   // element store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (req_acc) begin
         store_mem[load_cnt_ff[ADDR_W-1:0]] <= req_element_value;
      end
      if (issue) begin
         rd_data_ff <= store_mem[src_ff];
      end
   end

   assign push_beat.value = rd_data_ff;
   assign push_beat.last  = rd_last_ff;

   smrc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rd_pend_ff),
      .push_beat (push_beat),
      .pop       (pop),
      .head_beat (head_beat),
      .stat      (buf_stat)
   );

   assign csr_ready         = 1'b1;
   assign rsp_valid         = buf_stat.head_vld;
   assign rsp_rotated_value = $signed(head_beat.value);
   assign rsp_last_element  = head_beat.last;

   `SMRC_ASSERT_IMP(ap_buf_no_overflow, clock, reset,
      rd_pend_ff && buf_stat.head_vld && buf_stat.skid_vld, pop,
      "result buffer overflow")
   `SMRC_ASSERT_IMP(ap_load_bound, clock, reset,
      1'b1, load_cnt_ff < CNT_W'(DEPTH),
      "load count beyond store depth")
   `SMRC_ASSERT_NXT(ap_emit_start, clock, reset,
      complete, (state_ff == ST_EMIT) && (r_ff == '0) && (c_ff == '0) && (load_cnt_ff == '0),
      "emission did not start after final element")
   `SMRC_ASSERT_NXT(ap_last_read, clock, reset,
      issue && last_c && last_r, (state_ff == ST_LOAD) && rd_pend_ff && rd_last_ff,
      "final read did not return to loading")

endmodule

// ===== rtl/smrc_out_buf.sv =====
// ----------------------------------------------------------------------------
// smrc_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module smrc_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  smrc_pkg::beat_type    push_beat,
   input  logic                  pop,
   output smrc_pkg::beat_type    head_beat,
   output smrc_pkg::buf_stat_type stat
);

   smrc_pkg::beat_type head_ff, head_in;
   smrc_pkg::beat_type skid_ff, skid_in;
   logic head_vld_ff, head_vld_in;
   logic skid_vld_ff, skid_vld_in;

   always_comb begin
      head_in     = head_ff;
      skid_in     = skid_ff;
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      case ({push, pop})
         2'b11: begin
            if (skid_vld_ff) begin
               head_in = skid_ff;
               skid_in = push_beat;
            end else begin
               head_in = push_beat;
            end
         end
         2'b10: begin
            if (!head_vld_ff) begin
               head_in     = push_beat;
               head_vld_in = 1'b1;
            end else begin
               skid_in     = push_beat;
               skid_vld_in = 1'b1;
            end
         end
         2'b01: begin
            if (skid_vld_ff) begin
               head_in     = skid_ff;
               skid_vld_in = 1'b0;
            end else begin
               head_vld_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign head_beat     = head_ff;
   assign stat.head_vld = head_vld_ff;
   assign stat.skid_vld = skid_vld_ff;

endmodule
